### sv/clnw_pkg.sv
// Shared types and constants of the count to display nibble writer.
`timescale 1ns / 1ps

package clnw_pkg;

    localparam int VALUE_W     = 32;
    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int DIGITS      = 9;
    localparam int BCD_DIGITS  = 10;
    localparam int BEATS_INIT  = 10;
    localparam int BEATS_BYTE  = 2;
    localparam int BEATS_COUNT = 2 + 2 * DIGITS;
    localparam int MAX_BEATS   = (BEATS_COUNT > BEATS_INIT) ? BEATS_COUNT : BEATS_INIT;
    localparam int BEAT_IDX_W  = $clog2(MAX_BEATS);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_INIT  = 2'd0,
        FUNC_CMD   = 2'd1,
        FUNC_CHAR  = 2'd2,
        FUNC_COUNT = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]         func;
        logic [VALUE_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic             reg_select;
        logic [NIB_W-1:0] nibble;
        logic             last;
    } t_out_beat;

    typedef logic [DIGITS-1:0][NIB_W-1:0] t_digits;

    typedef struct packed {
        t_func             kind;
        logic [BYTE_W-1:0] data;
        t_digits           digits;
    } t_job;

endpackage

### sv/clnw_front.sv
// Front end: accepts requests and turns counts into decimal digits.
`timescale 1ns / 1ps

module clnw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  clnw_pkg::t_in_beat i_in_data,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output clnw_pkg::t_job     o_job
);

    localparam int STEPS = clnw_pkg::VALUE_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam int BCD_W = clnw_pkg::NIB_W * clnw_pkg::BCD_DIGITS;

    function automatic logic [BCD_W-1:0] adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int d = 0; d < clnw_pkg::BCD_DIGITS; d++) begin
            if (b[d*clnw_pkg::NIB_W +: clnw_pkg::NIB_W] >= 4'd5) begin
                r[d*clnw_pkg::NIB_W +: clnw_pkg::NIB_W] =
                    b[d*clnw_pkg::NIB_W +: clnw_pkg::NIB_W] + 4'd3;
            end
        end
        return r;
    endfunction

    logic                         r_busy, n_busy;
    logic                         r_job_vld, n_job_vld;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [clnw_pkg::VALUE_W-1:0] r_shift, n_shift;
    logic [BCD_W-1:0]             r_bcd, n_bcd;
    clnw_pkg::t_job               r_job, n_job;

    logic             in_fire;
    logic             push_fire;
    logic [BCD_W-1:0] adj0, step1, adj1, step2;

    assign o_in_ready  = !r_busy && (!r_job_vld || i_job_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign push_fire   = r_job_vld && i_job_ready;
    assign o_job_valid = r_job_vld;
    assign o_job       = r_job;

    assign adj0  = adjust(r_bcd);
    assign step1 = {adj0[BCD_W-2:0], r_shift[clnw_pkg::VALUE_W-1]};
    assign adj1  = adjust(step1);
    assign step2 = {adj1[BCD_W-2:0], r_shift[clnw_pkg::VALUE_W-2]};

    always_comb begin
        n_busy    = r_busy;
        n_job_vld = r_job_vld;
        n_cnt     = r_cnt;
        n_shift   = r_shift;
        n_bcd     = r_bcd;
        n_job     = r_job;
        if (push_fire) begin
            n_job_vld = 1'b0;
        end
        if (r_busy) begin
            n_shift = {r_shift[clnw_pkg::VALUE_W-3:0], 2'b00};
            n_bcd   = step2;
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_busy           = 1'b0;
                n_job_vld        = 1'b1;
                n_job.digits     = step2[clnw_pkg::DIGITS*clnw_pkg::NIB_W-1:0];
            end
        end
        if (in_fire) begin
            n_job.kind = clnw_pkg::t_func'(i_in_data.func);
            n_job.data = i_in_data.value[clnw_pkg::BYTE_W-1:0];
            case (clnw_pkg::t_func'(i_in_data.func))
                clnw_pkg::FUNC_COUNT: begin
                    n_busy  = 1'b1;
                    n_cnt   = '0;
                    n_shift = i_in_data.value;
                    n_bcd   = '0;
                end
                default: begin
                    n_job_vld = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_job_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_busy    <= n_busy;
            r_job_vld <= n_job_vld;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_job   <= n_job;
    end

endmodule

### sv/clnw_queue.sv
// Short job queue between the front end and the nibble sequencer.
`timescale 1ns / 1ps

module clnw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  clnw_pkg::t_job i_push,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output clnw_pkg::t_job o_pop
);

    localparam int PTR_W = (clnw_pkg::QUEUE_DEPTH > 1) ? $clog2(clnw_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(clnw_pkg::QUEUE_DEPTH + 1);

    clnw_pkg::t_job   r_mem [clnw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic push_fire;
    logic pop_fire;

    assign o_push_ready = (r_cnt != CNT_W'(clnw_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop        = r_mem[r_rd];
    assign push_fire    = i_push_valid && o_push_ready;
    assign pop_fire     = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_fire) begin
            n_wr = (r_wr == PTR_W'(clnw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_fire) begin
            n_rd = (r_rd == PTR_W'(clnw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_fire && !push_fire) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr] <= i_push;
        end
    end

endmodule

### sv/clnw_back.sv
// Back end: walks each job and sends its bytes as nibble beats.
`timescale 1ns / 1ps

module clnw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  clnw_pkg::t_job      i_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clnw_pkg::t_out_beat o_out_data
);

    localparam int IDX_W     = clnw_pkg::BEAT_IDX_W;
    localparam int BI_W      = IDX_W - 1;
    localparam int DIG_IDX_W = (clnw_pkg::DIGITS > 1) ? $clog2(clnw_pkg::DIGITS) : 1;

    localparam logic [clnw_pkg::BYTE_W-1:0] CMD_HOME    = 8'h02;
    localparam logic [clnw_pkg::BYTE_W-1:0] CMD_FUNC    = 8'h28;
    localparam logic [clnw_pkg::BYTE_W-1:0] CMD_DISPLAY = 8'h0C;
    localparam logic [clnw_pkg::BYTE_W-1:0] CMD_ENTRY   = 8'h06;
    localparam logic [clnw_pkg::BYTE_W-1:0] CMD_CLEAR   = 8'h01;
    localparam logic [clnw_pkg::NIB_W-1:0]  ASCII_HIGH  = 4'h3;

    logic                r_cur_vld, n_cur_vld;
    logic [IDX_W-1:0]    r_idx, n_idx;
    clnw_pkg::t_job      r_cur, n_cur;
    logic                r_out_vld, n_out_vld;
    clnw_pkg::t_out_beat r_out, n_out;

    logic                       slot_free;
    logic                       step;
    logic                       is_last;
    logic [IDX_W-1:0]           last_idx;
    logic [BI_W-1:0]            byte_idx;
    logic [IDX_W-1:0]           pos_full;
    logic [clnw_pkg::NIB_W-1:0] digit;
    logic [clnw_pkg::BYTE_W-1:0] cur_byte;
    logic                       cur_rs;
    clnw_pkg::t_out_beat        beat;

    assign slot_free   = !r_out_vld || i_out_ready;
    assign step        = r_cur_vld && slot_free;
    assign byte_idx    = r_idx[IDX_W-1:1];
    assign pos_full    = IDX_W'(clnw_pkg::DIGITS) - {1'b0, byte_idx};
    assign digit       = r_cur.digits[pos_full[DIG_IDX_W-1:0]];
    assign is_last     = (r_idx == last_idx);
    assign o_job_ready = !r_cur_vld || (step && is_last);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        last_idx = IDX_W'(clnw_pkg::BEATS_BYTE - 1);
        cur_byte = r_cur.data;
        cur_rs   = 1'b0;
        case (r_cur.kind)
            clnw_pkg::FUNC_INIT: begin
                last_idx = IDX_W'(clnw_pkg::BEATS_INIT - 1);
                case (byte_idx)
                    BI_W'(0): cur_byte = CMD_HOME;
                    BI_W'(1): cur_byte = CMD_FUNC;
                    BI_W'(2): cur_byte = CMD_DISPLAY;
                    BI_W'(3): cur_byte = CMD_ENTRY;
                    default:  cur_byte = CMD_CLEAR;
                endcase
            end
            clnw_pkg::FUNC_CMD: begin
                cur_byte = r_cur.data;
            end
            clnw_pkg::FUNC_CHAR: begin
                cur_rs = 1'b1;
            end
            clnw_pkg::FUNC_COUNT: begin
                last_idx = IDX_W'(clnw_pkg::BEATS_COUNT - 1);
                if (byte_idx == '0) begin
                    cur_byte = CMD_CLEAR;
                end else begin
                    cur_byte = {ASCII_HIGH, digit};
                    cur_rs   = 1'b1;
                end
            end
            default: begin
                cur_byte = r_cur.data;
            end
        endcase
        beat.reg_select = cur_rs;
        beat.nibble     = r_idx[0] ? cur_byte[clnw_pkg::NIB_W-1:0]
                                   : cur_byte[clnw_pkg::BYTE_W-1:clnw_pkg::NIB_W];
        beat.last       = is_last;
    end

    always_comb begin
        n_cur_vld = r_cur_vld;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (o_job_ready && i_job_valid) begin
            n_cur_vld = 1'b1;
            n_cur     = i_job;
            n_idx     = '0;
        end else if (step && is_last) begin
            n_cur_vld = 1'b0;
        end else if (step) begin
            n_idx = r_idx + 1'b1;
        end
        if (step) begin
            n_out_vld = 1'b1;
            n_out     = beat;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_cur_vld <= n_cur_vld;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

endmodule

### sv/count_to_lcd_nibble_writer_core.sv
// Top level of the count to display nibble writer.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_in_data  (func, value)
//   output    out        o_out_valid / i_out_ready  o_out_data (reg_select, nibble, last)
//
// The sequencer sends one nibble beat per cycle while the output is not
// stalled: 10 beats for init, 2 for a command or character, 20 for a count.
// A count is converted to decimal in the front end two bits per cycle,
// overlapped with the beats of earlier items. Reset is synchronous; it
// empties the queue and the output register. A stall on the output holds the
// beat and backs up through the queue to the input.
`timescale 1ns / 1ps

module count_to_lcd_nibble_writer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  clnw_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clnw_pkg::t_out_beat o_out_data
);

    logic           front_valid, front_ready;
    clnw_pkg::t_job front_job;
    logic           back_valid, back_ready;
    clnw_pkg::t_job back_job;

    clnw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    clnw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push       (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop        (back_job)
    );

    clnw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .i_job       (back_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### sv/clnw_checker.sv
// Port-level assertions for the nibble writer and their bind.
`timescale 1ns / 1ps

module clnw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input clnw_pkg::t_in_beat  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input clnw_pkg::t_out_beat o_out_data
);

    logic [3:0] r_pending;
    logic       in_fire;
    logic       end_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign end_fire = o_out_valid && i_out_ready && o_out_data.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_fire && !end_fire) begin
            r_pending <= r_pending + 1'b1;
        end else if (end_fire && !in_fire) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Output beat changed or dropped while stalled.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output beat shown right after reset.");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 4'd0)
        else $error("Output beat without an outstanding input item.");

endmodule

bind count_to_lcd_nibble_writer_core clnw_checker u_clnw_checker (.*);

### verif/clnw_nibble_checker.sv
// Checker that predicts the nibble beats of each request and compares them on the output.
`timescale 1ns / 1ps

module clnw_nibble_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  clnw_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  clnw_pkg::t_out_beat i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [clnw_pkg::BYTE_W-1:0] INIT_CMDS [5] =
        '{8'h02, 8'h28, 8'h0C, 8'h06, 8'h01};
    localparam logic [clnw_pkg::BYTE_W-1:0] CLEAR_CMD  = 8'h01;
    localparam logic [clnw_pkg::BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic                        RS_CMD     = 1'b0;
    localparam logic                        RS_CHAR    = 1'b1;

    clnw_pkg::t_out_beat expected_nibbles[$];
    int                  fail_total = 0;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        fail_total++;
    endtask

    task automatic push_byte(input logic rs, input logic [clnw_pkg::BYTE_W-1:0] data);
        clnw_pkg::t_out_beat beat;
        beat.reg_select = rs;
        beat.last       = 1'b0;
        beat.nibble     = data[7:4];
        expected_nibbles.push_back(beat);
        beat.nibble     = data[3:0];
        expected_nibbles.push_back(beat);
    endtask

    task automatic predict_nibbles(input clnw_pkg::t_in_beat req);
        longint unsigned     scale;
        longint unsigned     digit;
        clnw_pkg::t_out_beat tail;
        case (clnw_pkg::t_func'(req.func))
            clnw_pkg::FUNC_INIT: begin
                for (int i = 0; i < 5; i++) begin
                    push_byte(RS_CMD, INIT_CMDS[i]);
                end
            end
            clnw_pkg::FUNC_CMD: begin
                push_byte(RS_CMD, req.value[7:0]);
            end
            clnw_pkg::FUNC_CHAR: begin
                push_byte(RS_CHAR, req.value[7:0]);
            end
            clnw_pkg::FUNC_COUNT: begin
                push_byte(RS_CMD, CLEAR_CMD);
                scale = 1;
                for (int i = 1; i < clnw_pkg::DIGITS; i++) begin
                    scale = scale * 10;
                end
                for (int i = 0; i < clnw_pkg::DIGITS; i++) begin
                    digit = (longint'(req.value) / scale) % 10;
                    push_byte(RS_CHAR, ASCII_ZERO + digit[7:0]);
                    scale = scale / 10;
                    if (scale == 0) begin
                        scale = 1;
                    end
                end
            end
            default: begin
                push_byte(RS_CMD, req.value[7:0]);
            end
        endcase
        tail = expected_nibbles.pop_back();
        tail.last = 1'b1;
        expected_nibbles.push_back(tail);
    endtask

    always @(posedge i_clk) begin : watch
        clnw_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_nibbles.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat rs=%0b nibble=%h last=%0b",
                        i_out_data.reg_select, i_out_data.nibble, i_out_data.last));
                end else begin
                    want = expected_nibbles.pop_front();
                    if (i_out_data.reg_select !== want.reg_select) begin
                        report_mismatch($sformatf("reg_select got %0b want %0b",
                            i_out_data.reg_select, want.reg_select));
                    end
                    if (i_out_data.nibble !== want.nibble) begin
                        report_mismatch($sformatf("nibble got %h want %h",
                            i_out_data.nibble, want.nibble));
                    end
                    if (i_out_data.last !== want.last) begin
                        report_mismatch($sformatf("last got %0b want %0b",
                            i_out_data.last, want.last));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_nibbles(i_in_data);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_nibbles.size();
    end

endmodule

### verif/count_to_lcd_nibble_writer_core_test.sv
// Testbench top: drives display requests and output stalls, then gives the verdict.
`timescale 1ns / 1ps

module count_to_lcd_nibble_writer_core_test;

    localparam int RANDOM_REQUESTS = 200;
    localparam int CALM_TAIL       = 40;
    localparam int SETTLE_CYCLES   = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    clnw_pkg::t_in_beat  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    clnw_pkg::t_out_beat o_out_data;
    int                  fail_count;
    int                  pending_nibbles;
    bit                  send_idle_en;
    bit                  drain_stall_en;

    count_to_lcd_nibble_writer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    clnw_nibble_checker nibble_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_nibbles)
    );

    initial i_clk = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_request(input clnw_pkg::t_func func,
                                input logic [clnw_pkg::VALUE_W-1:0] value);
        clnw_pkg::t_in_beat req;
        req.func  = func;
        req.value = value;
        if (send_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [clnw_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: pick_value = $urandom_range(0, 999);
            1: pick_value = 32'd999_999_999 + $urandom_range(0, 2) - 1;
            2: pick_value = ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 255);
            default: pick_value = $urandom;
        endcase
    endfunction

    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (drain_stall_en && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in_data      <= '0;
        send_idle_en   <= 1'b1;
        drain_stall_en <= 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(clnw_pkg::FUNC_INIT,  32'h0000_0000);
        send_request(clnw_pkg::FUNC_INIT,  32'hFFFF_FFFF);
        send_request(clnw_pkg::FUNC_CMD,   32'h0000_0000);
        send_request(clnw_pkg::FUNC_CMD,   32'h0000_00FF);
        send_request(clnw_pkg::FUNC_CMD,   32'hFFFF_FF5A);
        send_request(clnw_pkg::FUNC_CMD,   32'hAAAA_AA00);
        send_request(clnw_pkg::FUNC_CHAR,  32'h0000_0000);
        send_request(clnw_pkg::FUNC_CHAR,  32'h0000_00FF);
        send_request(clnw_pkg::FUNC_CHAR,  32'h5555_5541);
        send_request(clnw_pkg::FUNC_CHAR,  32'hFFFF_FFA5);
        send_request(clnw_pkg::FUNC_COUNT, 32'd0);
        send_request(clnw_pkg::FUNC_COUNT, 32'd1);
        send_request(clnw_pkg::FUNC_COUNT, 32'd123_456_789);
        send_request(clnw_pkg::FUNC_COUNT, 32'd999_999_999);
        send_request(clnw_pkg::FUNC_COUNT, 32'd1_000_000_000);
        send_request(clnw_pkg::FUNC_COUNT, 32'h8000_0000);
        send_request(clnw_pkg::FUNC_COUNT, 32'hFFFF_FFFF);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS - CALM_TAIL) begin
                send_idle_en   <= 1'b0;
                drain_stall_en <= 1'b0;
            end
            send_request(clnw_pkg::t_func'($urandom_range(0, 3)), pick_value());
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_nibbles != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_nibbles == 0) begin
            $display("count_to_lcd_nibble_writer_core_test: PASS");
        end else begin
            $display("count_to_lcd_nibble_writer_core_test: FAIL");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("count_to_lcd_nibble_writer_core_test: FAIL");
        $finish;
    end

endmodule
